// ----- hw/rtl/padc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// padc_pkg
// Shared types and constants of the parallel converter read sequencer.
// ----------------------------------------------------------------------------
package padc_pkg;

    // sizing of the attached converter
    localparam int MAX_CHANNELS = 8;
    localparam int DATA_WIDTH   = 16;
    localparam int CNT_W        = 4;
    localparam int TIMER_W      = 8;
    localparam logic [15:0] DATA_MASK = 16'((32'h1 << DATA_WIDTH) - 1);

    // configuration register indexes
    localparam logic [2:0] REG_CHANNEL_COUNT  = 3'd0;
    localparam logic [2:0] REG_CONVST_CYCLES  = 3'd1;
    localparam logic [2:0] REG_RD_LOW_CYCLES  = 3'd2;
    localparam logic [2:0] REG_RD_HIGH_CYCLES = 3'd3;
    localparam logic [2:0] REG_CS_HOLD_CYCLES = 3'd4;

    // configuration reset values
    localparam logic [3:0] RST_CHANNEL_COUNT  = 4'd8;
    localparam logic [7:0] RST_CONVST_CYCLES  = 8'd3;
    localparam logic [7:0] RST_RD_LOW_CYCLES  = 8'd3;
    localparam logic [7:0] RST_RD_HIGH_CYCLES = 8'd2;
    localparam logic [7:0] RST_CS_HOLD_CYCLES = 8'd2;

    // sequencer phases, one-hot
    typedef enum logic [7:0] {
        PH_IDLE      = 8'b0000_0001,
        PH_CONV_LOW  = 8'b0000_0010,
        PH_CONV_HIGH = 8'b0000_0100,
        PH_WAIT_RISE = 8'b0000_1000,
        PH_WAIT_FALL = 8'b0001_0000,
        PH_RD_LOW    = 8'b0010_0000,
        PH_RD_HIGH   = 8'b0100_0000,
        PH_CS_HOLD   = 8'b1000_0000
    } t_phase;

    // live configuration
    typedef struct packed {
        logic [3:0] channel_count;
        logic [7:0] convst_cycles;
        logic [7:0] rd_low_cycles;
        logic [7:0] rd_high_cycles;
        logic [7:0] cs_hold_cycles;
    } t_cfg;

    // one tick of pin input
    typedef struct packed {
        logic        start_request;
        logic        busy_level;
        logic [15:0] data_bus;
    } t_tick_in;

    // one tick of pin output
    typedef struct packed {
        logic        convst_n;
        logic        cs_n;
        logic        rd_n;
        logic        sample_valid;
        logic [15:0] sample_value;
        logic [2:0]  channel_index;
        logic        last_sample;
        logic        idle;
    } t_tick_out;

endpackage
`default_nettype wire

// ----- hw/rtl/padc_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// padc_cfg_regs
// Write-only configuration registers with their reset values.
// ----------------------------------------------------------------------------
module padc_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [7:0]    i_cfg_data,
    output padc_pkg::t_cfg     o_cfg
);

    padc_pkg::t_cfg r_cfg;

    // register writes, unknown indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.channel_count  <= padc_pkg::RST_CHANNEL_COUNT;
            r_cfg.convst_cycles  <= padc_pkg::RST_CONVST_CYCLES;
            r_cfg.rd_low_cycles  <= padc_pkg::RST_RD_LOW_CYCLES;
            r_cfg.rd_high_cycles <= padc_pkg::RST_RD_HIGH_CYCLES;
            r_cfg.cs_hold_cycles <= padc_pkg::RST_CS_HOLD_CYCLES;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                padc_pkg::REG_CHANNEL_COUNT:  r_cfg.channel_count  <= i_cfg_data[3:0];
                padc_pkg::REG_CONVST_CYCLES:  r_cfg.convst_cycles  <= i_cfg_data;
                padc_pkg::REG_RD_LOW_CYCLES:  r_cfg.rd_low_cycles  <= i_cfg_data;
                padc_pkg::REG_RD_HIGH_CYCLES: r_cfg.rd_high_cycles <= i_cfg_data;
                padc_pkg::REG_CS_HOLD_CYCLES: r_cfg.cs_hold_cycles <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- hw/rtl/padc_seq_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// padc_seq_core
// Phase state, timer and channel counter; computes one tick of pin output.
// ----------------------------------------------------------------------------
module padc_seq_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_advance,
    input  padc_pkg::t_cfg      i_cfg,
    input  padc_pkg::t_tick_in  i_tick,
    output padc_pkg::t_tick_out o_tick
);

    padc_pkg::t_phase r_phase, n_phase;
    logic [padc_pkg::TIMER_W-1:0] r_timer, n_timer;
    logic [padc_pkg::CNT_W-1:0]   r_chan, n_chan;

    logic [padc_pkg::TIMER_W:0]   timer_inc;
    logic [padc_pkg::CNT_W-1:0]   chan_used;
    logic                         chan_last;
    logic                         conv_done, rdl_done, rdh_done, hold_done;

    // phase end: timer + 1 >= length, a zero length ends after one tick
    assign timer_inc = {1'b0, r_timer} + 1'b1;
    assign conv_done = timer_inc >= {1'b0, i_cfg.convst_cycles};
    assign rdl_done  = timer_inc >= {1'b0, i_cfg.rd_low_cycles};
    assign rdh_done  = timer_inc >= {1'b0, i_cfg.rd_high_cycles};
    assign hold_done = timer_inc >= {1'b0, i_cfg.cs_hold_cycles};

    // effective channel count, clamped to one .. max
    always_comb begin
        if (i_cfg.channel_count == '0) begin
            chan_used = padc_pkg::CNT_W'(1);
        end else if (i_cfg.channel_count > padc_pkg::CNT_W'(padc_pkg::MAX_CHANNELS)) begin
            chan_used = padc_pkg::CNT_W'(padc_pkg::MAX_CHANNELS);
        end else begin
            chan_used = i_cfg.channel_count;
        end
    end

    assign chan_last = ({1'b0, r_chan} + 1'b1) >= {1'b0, chan_used};

    // next state and pin levels for this tick
    always_comb begin
        n_phase = r_phase;
        n_timer = r_timer;
        n_chan  = r_chan;

        o_tick               = '0;
        o_tick.convst_n      = 1'b1;
        o_tick.cs_n          = 1'b1;
        o_tick.rd_n          = 1'b1;
        o_tick.idle          = (r_phase == padc_pkg::PH_IDLE);

        case (r_phase)
            padc_pkg::PH_IDLE: begin
                if (i_tick.start_request) begin
                    n_chan  = '0;
                    n_phase = padc_pkg::PH_CONV_LOW;
                    n_timer = '0;
                end
            end
            padc_pkg::PH_CONV_LOW: begin
                o_tick.convst_n = 1'b0;
                if (conv_done) begin
                    n_phase = padc_pkg::PH_CONV_HIGH;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc[padc_pkg::TIMER_W-1:0];
                end
            end
            padc_pkg::PH_CONV_HIGH: begin
                if (conv_done) begin
                    n_phase = padc_pkg::PH_WAIT_RISE;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc[padc_pkg::TIMER_W-1:0];
                end
            end
            padc_pkg::PH_WAIT_RISE: begin
                if (i_tick.busy_level) begin
                    n_phase = padc_pkg::PH_WAIT_FALL;
                    n_timer = '0;
                end
            end
            padc_pkg::PH_WAIT_FALL: begin
                if (!i_tick.busy_level) begin
                    n_chan  = '0;
                    n_phase = padc_pkg::PH_RD_LOW;
                    n_timer = '0;
                end
            end
            padc_pkg::PH_RD_LOW: begin
                o_tick.cs_n = 1'b0;
                o_tick.rd_n = 1'b0;
                if (rdl_done) begin
                    // latch the bus on the last low tick
                    o_tick.sample_valid  = 1'b1;
                    o_tick.sample_value  = i_tick.data_bus & padc_pkg::DATA_MASK;
                    o_tick.channel_index = r_chan[2:0];
                    o_tick.last_sample   = chan_last;
                    n_phase = padc_pkg::PH_RD_HIGH;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc[padc_pkg::TIMER_W-1:0];
                end
            end
            padc_pkg::PH_RD_HIGH: begin
                o_tick.cs_n = 1'b0;
                if (rdh_done) begin
                    n_timer = '0;
                    if (chan_last) begin
                        n_phase = padc_pkg::PH_CS_HOLD;
                    end else begin
                        n_chan  = r_chan + 1'b1;
                        n_phase = padc_pkg::PH_RD_LOW;
                    end
                end else begin
                    n_timer = timer_inc[padc_pkg::TIMER_W-1:0];
                end
            end
            padc_pkg::PH_CS_HOLD: begin
                if (hold_done) begin
                    n_chan  = '0;
                    n_phase = padc_pkg::PH_IDLE;
                    n_timer = '0;
                end else begin
                    n_timer = timer_inc[padc_pkg::TIMER_W-1:0];
                end
            end
            default: begin
                n_phase = padc_pkg::PH_IDLE;
                n_timer = '0;
                n_chan  = '0;
            end
        endcase
    end

    // state update once per accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= padc_pkg::PH_IDLE;
            r_timer <= '0;
            r_chan  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_timer <= n_timer;
            r_chan  <= n_chan;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/parallel_adc_conversion_reader.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A result is registered in the output register in the cycle after its tick is accepted.
// Throughput: one tick per cycle; the output register lets a new tick in whenever
// it is empty or being drained in the same cycle.
// Reset (synchronous, active low) returns the sequencer to idle, clears timer and
// channel counter, loads register defaults and empties the output register.
// ----------------------------------------------------------------------------
// parallel_adc_conversion_reader
// Convert-and-read sequencer for a parallel-bus converter, one tick per transaction.
// ----------------------------------------------------------------------------
module parallel_adc_conversion_reader (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_start_request,
    input  wire logic        i_busy_level,
    input  wire logic [15:0] i_data_bus,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_convst_n,
    output logic             o_cs_n,
    output logic             o_rd_n,
    output logic             o_sample_valid,
    output logic [15:0]      o_sample_value,
    output logic [2:0]       o_channel_index,
    output logic             o_last_sample,
    output logic             o_idle
);

    padc_pkg::t_cfg      cfg;
    padc_pkg::t_tick_in  tick_in;
    padc_pkg::t_tick_out tick_out;
    padc_pkg::t_tick_out r_out;
    logic                r_out_valid;
    logic                accept;

    // configuration registers
    padc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input handshake
    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    assign tick_in.start_request = i_start_request;
    assign tick_in.busy_level    = i_busy_level;
    assign tick_in.data_bus      = i_data_bus;

    // sequencer
    padc_seq_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (accept),
        .i_cfg     (cfg),
        .i_tick    (tick_in),
        .o_tick    (tick_out)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= tick_out;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_convst_n      = r_out.convst_n;
    assign o_cs_n          = r_out.cs_n;
    assign o_rd_n          = r_out.rd_n;
    assign o_sample_valid  = r_out.sample_valid;
    assign o_sample_value  = r_out.sample_value;
    assign o_channel_index = r_out.channel_index;
    assign o_last_sample   = r_out.last_sample;
    assign o_idle          = r_out.idle;

endmodule
`default_nettype wire

// ----- hw/rtl/padc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// padc_checker
// Port-level assertions on the sequencer result stream.
// ----------------------------------------------------------------------------
module padc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_convst_n,
    input wire logic        o_cs_n,
    input wire logic        o_rd_n,
    input wire logic        o_sample_valid,
    input wire logic [15:0] o_sample_value,
    input wire logic [2:0]  o_channel_index,
    input wire logic        o_last_sample,
    input wire logic        o_idle
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sample_value)
            && $stable(o_sample_valid) && $stable(o_channel_index))
        else $error("stalled result changed");

    // samples are only taken with chip select and read strobe low
    a_sample_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sample_valid |-> !o_rd_n && !o_cs_n && o_convst_n)
        else $error("sample outside read strobe");

    // idle drives all pins inactive
    a_idle_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_idle |-> o_convst_n && o_cs_n && o_rd_n && !o_sample_valid)
        else $error("pin active while idle");

    // read strobe never low without chip select
    a_rd_in_cs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_rd_n |-> !o_cs_n)
        else $error("read strobe without chip select");

    // sample fields are zero when no sample
    a_no_sample_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_sample_valid |->
            o_sample_value == 16'd0 && o_channel_index == 3'd0 && !o_last_sample)
        else $error("sample fields set without sample");

endmodule

bind parallel_adc_conversion_reader padc_checker u_padc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_convst_n      (o_convst_n),
    .o_cs_n          (o_cs_n),
    .o_rd_n          (o_rd_n),
    .o_sample_valid  (o_sample_valid),
    .o_sample_value  (o_sample_value),
    .o_channel_index (o_channel_index),
    .o_last_sample   (o_last_sample),
    .o_idle          (o_idle)
);
`default_nettype wire

// ----- verif/tb_parallel_adc_conversion_reader.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_parallel_adc_conversion_reader
// Drives pin ticks into the converter read sequencer and checks every output
// tick against a cycle-level model of the convert/wait/read/hold sequence,
// across several register settings, random gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb_parallel_adc_conversion_reader;
    import padc_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    // clock, reset and block inputs, all known from time zero
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_cfg_we        = 1'b0;
    logic [2:0]  i_cfg_index     = '0;
    logic [7:0]  i_cfg_data      = '0;
    logic        i_in_valid      = 1'b0;
    logic        i_start_request = 1'b0;
    logic        i_busy_level    = 1'b0;
    logic [15:0] i_data_bus      = '0;
    logic        i_out_stall     = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_convst_n;
    logic        o_cs_n;
    logic        o_rd_n;
    logic        o_sample_valid;
    logic [15:0] o_sample_value;
    logic [2:0]  o_channel_index;
    logic        o_last_sample;
    logic        o_idle;

    // sequencer model state and live register copy
    t_cfg       seq_cfg = '{RST_CHANNEL_COUNT, RST_CONVST_CYCLES, RST_RD_LOW_CYCLES,
                            RST_RD_HIGH_CYCLES, RST_CS_HOLD_CYCLES};
    t_phase     seq_phase = PH_IDLE;
    logic [7:0] seq_timer = '0;
    logic [3:0] seq_chan  = '0;

    // pending pin ticks and expected output ticks
    t_tick_in  tick_queue[$];
    t_tick_out expected_ticks[$];

    int queued_total    = 0;
    int ticks_accepted  = 0;
    int samples_seen    = 0;
    int conversions_seen = 0;
    int settings_loaded = 0;
    int squeeze_count   = 0;
    int mismatch_count  = 0;
    int cycle_count     = 0;

    int send_gap  = 0;
    int send_run  = 0;
    bit send_calm = 1'b0;
    int stall_left   = 0;
    int squeeze_left = 0;
    int recv_run     = 0;
    bit recv_calm    = 1'b0;
    int quiet_cycles = 0;

    parallel_adc_conversion_reader u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_start_request (i_start_request),
        .i_busy_level    (i_busy_level),
        .i_data_bus      (i_data_bus),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_convst_n      (o_convst_n),
        .o_cs_n          (o_cs_n),
        .o_rd_n          (o_rd_n),
        .o_sample_valid  (o_sample_valid),
        .o_sample_value  (o_sample_value),
        .o_channel_index (o_channel_index),
        .o_last_sample   (o_last_sample),
        .o_idle          (o_idle)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------

    // a zero tick count behaves as one
    function automatic int ticks_of(logic [7:0] len);
        return (len == 8'd0) ? 1 : int'(len);
    endfunction

    // zero channels read one, too many saturate
    function automatic int channels_in_use();
        if (seq_cfg.channel_count == 4'd0) return 1;
        if (int'(seq_cfg.channel_count) > MAX_CHANNELS) return MAX_CHANNELS;
        return int'(seq_cfg.channel_count);
    endfunction

    function automatic void enter_phase(t_phase next_phase);
        seq_phase = next_phase;
        seq_timer = '0;
    endfunction

    // true on the last tick of a timed phase, otherwise counts on
    function automatic bit timer_expired(logic [7:0] len);
        if (int'(seq_timer) + 1 >= ticks_of(len)) return 1'b1;
        seq_timer = seq_timer + 8'd1;
        return 1'b0;
    endfunction

    function automatic void apply_register(logic [2:0] index, logic [7:0] data);
        case (index)
            REG_CHANNEL_COUNT:  seq_cfg.channel_count  = data[3:0];
            REG_CONVST_CYCLES:  seq_cfg.convst_cycles  = data;
            REG_RD_LOW_CYCLES:  seq_cfg.rd_low_cycles  = data;
            REG_RD_HIGH_CYCLES: seq_cfg.rd_high_cycles = data;
            REG_CS_HOLD_CYCLES: seq_cfg.cs_hold_cycles = data;
            default: ;
        endcase
    endfunction

    // pins show the phase at the start of the tick, the phase moves at its end
    function automatic t_tick_out sequence_tick(t_tick_in pins);
        t_tick_out r;
        r          = '0;
        r.convst_n = 1'b1;
        r.cs_n     = 1'b1;
        r.rd_n     = 1'b1;
        r.idle     = (seq_phase == PH_IDLE);
        case (seq_phase)
            PH_IDLE: begin
                if (pins.start_request) begin
                    seq_chan = '0;
                    enter_phase(PH_CONV_LOW);
                end
            end
            PH_CONV_LOW: begin
                r.convst_n = 1'b0;
                if (timer_expired(seq_cfg.convst_cycles)) enter_phase(PH_CONV_HIGH);
            end
            PH_CONV_HIGH: begin
                if (timer_expired(seq_cfg.convst_cycles)) enter_phase(PH_WAIT_RISE);
            end
            PH_WAIT_RISE: begin
                if (pins.busy_level) enter_phase(PH_WAIT_FALL);
            end
            PH_WAIT_FALL: begin
                if (!pins.busy_level) begin
                    seq_chan = '0;
                    enter_phase(PH_RD_LOW);
                end
            end
            PH_RD_LOW: begin
                r.cs_n = 1'b0;
                r.rd_n = 1'b0;
                if (timer_expired(seq_cfg.rd_low_cycles)) begin
                    r.sample_valid  = 1'b1;
                    r.sample_value  = pins.data_bus & DATA_MASK;
                    r.channel_index = seq_chan[2:0];
                    r.last_sample   = (int'(seq_chan) + 1 >= channels_in_use());
                    enter_phase(PH_RD_HIGH);
                end
            end
            PH_RD_HIGH: begin
                r.cs_n = 1'b0;
                if (timer_expired(seq_cfg.rd_high_cycles)) begin
                    if (int'(seq_chan) + 1 >= channels_in_use()) begin
                        enter_phase(PH_CS_HOLD);
                    end else begin
                        seq_chan = seq_chan + 4'd1;
                        enter_phase(PH_RD_LOW);
                    end
                end
            end
            default: begin
                if (timer_expired(seq_cfg.cs_hold_cycles)) begin
                    seq_chan = '0;
                    enter_phase(PH_IDLE);
                end
            end
        endcase
        return r;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    function automatic bit coin(int n);
        return ($urandom_range(0, n - 1) == 0);
    endfunction

    // mostly no pause, sometimes a short one, rarely a long one
    function automatic int pick_pause(bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_tick(bit start, bit busy, logic [15:0] bus);
        t_tick_in t;
        t.start_request = start;
        t.busy_level    = busy;
        t.data_bus      = bus;
        tick_queue.push_back(t);
        queued_total++;
    endfunction

    // one full conversion timed from the current registers, random bus content
    function automatic void queue_conversion(bit noisy);
        int conv_ticks;
        int read_ticks;
        conv_ticks = 2 * ticks_of(seq_cfg.convst_cycles);
        read_ticks = channels_in_use() * (ticks_of(seq_cfg.rd_low_cycles)
                     + ticks_of(seq_cfg.rd_high_cycles)) + ticks_of(seq_cfg.cs_hold_cycles);
        queue_tick(1'b1, noisy && coin(2), 16'($urandom));
        repeat (conv_ticks) queue_tick(noisy && coin(8), noisy && coin(4), 16'($urandom));
        repeat ($urandom_range(0, 3)) queue_tick(noisy && coin(8), 1'b0, 16'($urandom));
        repeat ($urandom_range(1, 5)) queue_tick(noisy && coin(8), 1'b1, 16'($urandom));
        repeat (read_ticks + $urandom_range(1, 3)) queue_tick(1'b0, 1'b0, 16'($urandom));
    endfunction

    // mostly full conversions, many with pin noise, the rest random pin noise
    function automatic void queue_random(int count);
        int target;
        target = queued_total + count;
        while (queued_total < target) begin
            if (coin(7)) begin
                repeat ($urandom_range(3, 25))
                    queue_tick(coin(2), coin(2), 16'($urandom));
            end else begin
                queue_conversion(!coin(3));
            end
        end
    endfunction

    task automatic write_register(logic [2:0] index, logic [7:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_register(index, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_setting(logic [7:0] channels, logic [7:0] convst,
                                logic [7:0] rd_low, logic [7:0] rd_high, logic [7:0] hold);
        write_register(REG_CHANNEL_COUNT, channels);
        write_register(REG_CONVST_CYCLES, convst);
        write_register(REG_RD_LOW_CYCLES, rd_low);
        write_register(REG_RD_HIGH_CYCLES, rd_high);
        write_register(REG_CS_HOLD_CYCLES, hold);
        settings_loaded++;
    endtask

    // wait until every tick went through and every output tick came back
    task automatic wait_quiet();
        do @(posedge i_clk);
        while (tick_queue.size() != 0 || i_in_valid || expected_ticks.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tick_in seen;
        t_tick_in nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            // transaction accepted on this edge
            if (i_in_valid && !o_in_stall) begin
                seen.start_request = i_start_request;
                seen.busy_level    = i_busy_level;
                seen.data_bus      = i_data_bus;
                expected_ticks.push_back(sequence_tick(seen));
                ticks_accepted++;
            end
            // present the next tick unless the current one is held
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (tick_queue.size() != 0) begin
                    nxt = tick_queue.pop_front();
                    i_start_request <= nxt.start_request;
                    i_busy_level    <= nxt.busy_level;
                    i_data_bus      <= nxt.data_bus;
                    i_in_valid      <= 1'b1;
                    if (send_run == 0) begin
                        send_run  = $urandom_range(20, 200);
                        send_calm = coin(3);
                    end
                    send_run--;
                    send_gap = pick_pause(send_calm);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output back-pressure, with an occasional long hold-off
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        quiet_cycles++;
        if (recv_run == 0) begin
            recv_run  = $urandom_range(20, 200);
            recv_calm = coin(3);
        end
        recv_run--;
        if (squeeze_left == 0 && tick_queue.size() >= 40 && quiet_cycles > 400) begin
            squeeze_left = $urandom_range(60, 120);
            squeeze_count++;
            quiet_cycles = 0;
        end
        if (squeeze_left > 0) begin
            squeeze_left--;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
            stall_left = pick_pause(recv_calm);
        end
    end

    // ------------------------------------------------------------------
    // output monitor
    // ------------------------------------------------------------------
    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tick_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_ticks.size() == 0) begin
                $error("output transaction with no tick pending");
                mismatch_count++;
            end else begin
                want = expected_ticks.pop_front();
                check_field("convst_n", 16'(want.convst_n), 16'(o_convst_n));
                check_field("cs_n", 16'(want.cs_n), 16'(o_cs_n));
                check_field("rd_n", 16'(want.rd_n), 16'(o_rd_n));
                check_field("sample_valid", 16'(want.sample_valid), 16'(o_sample_valid));
                check_field("sample_value", want.sample_value, o_sample_value);
                check_field("channel_index", 16'(want.channel_index), 16'(o_channel_index));
                check_field("last_sample", 16'(want.last_sample), 16'(o_last_sample));
                check_field("idle", 16'(want.idle), 16'(o_idle));
                if (want.sample_valid) samples_seen++;
                if (want.sample_valid && want.last_sample) conversions_seen++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero counts stretch to one tick, zero channels read one channel
        load_setting(8'hF0, 8'd0, 8'd0, 8'd0, 8'd0);
        queue_tick(1'b1, 1'b1, 16'h0000);   // start with busy already high
        queue_tick(1'b1, 1'b1, 16'h0000);   // convert low, start ignored
        queue_tick(1'b1, 1'b1, 16'hFFFF);   // convert high
        queue_tick(1'b0, 1'b1, 16'hFFFF);   // rise seen at once
        queue_tick(1'b0, 1'b0, 16'hFFFF);   // fall seen at once
        queue_tick(1'b1, 1'b0, 16'hFFFF);   // read low, sample all ones
        queue_tick(1'b1, 1'b1, 16'h0000);   // read high
        queue_tick(1'b0, 1'b0, 16'h0000);   // chip select hold
        wait_quiet();

        // channel count above the maximum, start held high up to the chip select hold
        load_setting(8'h0F, 8'd1, 8'd1, 8'd1, 8'd1);
        queue_tick(1'b1, 1'b0, 16'h0000);
        queue_tick(1'b1, 1'b0, 16'hFFFF);
        queue_tick(1'b1, 1'b0, 16'hFFFF);
        queue_tick(1'b1, 1'b0, 16'h0000);   // busy not yet up
        queue_tick(1'b1, 1'b1, 16'h0000);
        queue_tick(1'b1, 1'b1, 16'h0000);   // busy still up
        queue_tick(1'b1, 1'b0, 16'h0000);
        for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
            queue_tick(1'b1, 1'b0, ch[0] ? 16'hFFFF : 16'h0000);
            queue_tick(1'b1, 1'b0, ch[0] ? 16'h0000 : 16'hFFFF);
        end
        queue_tick(1'b0, 1'b0, 16'h0000);
        wait_quiet();

        // random traffic under a range of register settings
        for (int step = 1; step <= 7; step++) begin
            case (step)
                1: load_setting(8'(RST_CHANNEL_COUNT), RST_CONVST_CYCLES,
                                RST_RD_LOW_CYCLES, RST_RD_HIGH_CYCLES, RST_CS_HOLD_CYCLES);
                2: load_setting(8'd1, 8'd1, 8'd1, 8'd1, 8'd1);
                3: load_setting(8'($urandom_range(1, 8)), 8'($urandom_range(1, 5)),
                                8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
                                8'($urandom_range(1, 5)));
                4: begin
                    // writes to unused indexes must not disturb anything
                    write_register(3'(REG_CS_HOLD_CYCLES + 3'($urandom_range(1, 3))),
                                   8'($urandom));
                    load_setting({4'($urandom), 4'($urandom_range(9, 15))},
                                 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                                 8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
                    write_register(3'(REG_CS_HOLD_CYCLES + 3'($urandom_range(1, 3))),
                                   8'($urandom));
                end
                5: load_setting(8'($urandom_range(0, 15)), 8'($urandom_range(0, 8)),
                                8'($urandom_range(0, 8)), 8'($urandom_range(0, 8)),
                                8'($urandom_range(0, 8)));
                6: load_setting(8'd1, 8'd40, 8'd255, 8'd40, 8'd40);
                default: load_setting(8'($urandom_range(1, 8)), 8'($urandom_range(1, 3)),
                                      8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                                      8'($urandom_range(1, 3)));
            endcase
            if (step == 6) begin
                // one slow conversion, then leave a new one running so the
                // next setting lands mid-sequence
                queue_conversion(1'b0);
                queue_tick(1'b1, 1'b0, 16'($urandom));
                repeat (3) queue_tick(1'b0, 1'b0, 16'($urandom));
            end else begin
                queue_random(85);
            end
            wait_quiet();
        end

        $display("%0d ticks under %0d register settings, %0d long output hold-offs",
                 ticks_accepted, settings_loaded, squeeze_count);
        $display("%0d channel samples checked in %0d completed conversions",
                 samples_seen, conversions_seen);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
